[rtl/core/lmjm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lmjm_pkg;

   localparam int unsigned LOG_TABLE_BITS_DEF = 6;

   localparam logic [15:0] ONE_MINUS_LAMBDA_RST = 16'd52429;
   localparam logic [47:0] INV_LAMBDA_PROB_RST  = 48'd65536;
   localparam logic [31:0] QUERY_BOOST_RST      = 32'd65536;

   localparam logic [31:0] LN2_Q32 = 32'd2977044472;

   typedef enum logic [2:0] {
      REG_ONE_MINUS_LAMBDA = 3'd0,
      REG_INV_LAMBDA_PROB  = 3'd1,
      REG_QUERY_BOOST      = 3'd2,
      REG_MERGE_MODE       = 3'd3,
      REG_USE_FILTER_BOOST = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      MERGE_WRITE = 2'd0,
      MERGE_ADD   = 2'd1,
      MERGE_MAX   = 2'd2,
      MERGE_SPARE = 2'd3
   } merge_type;

   typedef struct packed {
      logic [31:0] doc_boost;
      logic [31:0] prior_score;
      logic        last;
      logic        zero_len;
   } side_type;

   function automatic logic [16:0] log_entry(input int unsigned i, input int unsigned b);
      logic [63:0] y;
      logic [16:0] res;
      res = '0;
      if (i >= (32'd1 << b)) begin
         res = 17'd65536;
      end else begin
         y = 64'(((32'd1 << b) + i)) << (30 - b);
         for (int k = 1; k <= 16; k++) begin
            y = (y * y) >> 30;
            if (y >= (64'd2 << 30)) begin
               y = y >> 1;
               res[16 - k] = 1'b1;
            end
         end
      end
      return res;
   endfunction

   function automatic logic [31:0] sat32(input logic signed [63:0] v);
      logic [31:0] res;
      if (v > 64'sd2147483647) begin
         res = 32'h7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         res = 32'h8000_0000;
      end else begin
         res = v[31:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

[rtl/core/lm_jelinek_mercer_doc_scorer_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Scores one posting entry per clock. Each word passes one input stage, 64 stages of a
// restoring divider that produce one quotient bit each, and 15 stages for the ratio
// multiply, the log2 interpolation, the boosts and the merge. A stalled result stalls the
// whole pipeline, so a word is taken whenever the result register is empty or being read.
// The user must write configuration on the csr port with no word in flight; not enforced.
module lm_jelinek_mercer_doc_scorer_core
   import lmjm_pkg::*;
#(
   parameter int unsigned LOG_TABLE_BITS = LOG_TABLE_BITS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // term_freq [31:0], doc_length [63:32], doc_boost [95:64], prior_score [127:96]
   input  wire logic [127:0] req_tdata,
   input  wire logic         req_tlast,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // score [31:0]
   output logic [31:0]       rsp_tdata,
   output logic              rsp_tlast,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [2:0]   csr_index,
   input  wire logic [47:0]  csr_data
);

   localparam int unsigned TB    = LOG_TABLE_BITS;
   localparam int unsigned TSIZE = (1 << TB) + 1;
   localparam int unsigned RW    = 32 - TB;
   localparam int unsigned NDIV  = 64;
   localparam int unsigned NPOST = 15;

   logic [15:0] oml_ff;
   logic [47:0] ilp_ff;
   logic [31:0] qb_ff;
   logic [1:0]  merge_ff;
   logic        ufb_ff;

   logic        adv;
   logic [16:0] log_tab [TSIZE];

   logic [31:0] div_rem_ff [NDIV+1];
   logic [63:0] div_nq_ff  [NDIV+1];
   logic [31:0] div_dl_ff  [NDIV+1];
   side_type    div_side_ff[NDIV+1];
   logic        div_vld_ff [NDIV+1];

   logic        pv_ff [NPOST];
   side_type    ps_ff [NPOST];

   logic [63:0]  m00_ff, m11_ff, m01_ff, m10_ff;
   logic [64:0]  mid_ff;
   logic [63:0]  lo_ff;
   logic [47:0]  hi_ff;
   logic [111:0] full_in;
   logic [47:0]  ratio_ff;
   logic [48:0]  x_ff, x4_ff;
   logic [5:0]   p_ff, p_in;
   logic [48:0]  xn_in;
   logic [31:0]  f_ff;
   logic [5:0]   e4_ff, e5_ff, e6_ff;
   logic [16:0]  t0_ff, t1_ff, t0b_ff;
   logic [RW-1:0] rem_ff;
   logic [16+RW:0] dp_ff;
   logic [21:0]  l_ff;
   logic [53:0]  ll_ff;
   logic [54:0]  round_in;
   logic [21:0]  partial_in;
   logic signed [54:0] pq_ff;
   logic [31:0]  r_ff, r11_ff, rf_ff, score_ff;
   logic signed [63:0] rfb_ff;
   logic signed [32:0] sum_in;

   assign adv        = !pv_ff[NPOST-1] || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = pv_ff[NPOST-1];
   assign rsp_tlast  = ps_ff[NPOST-1].last;
   assign rsp_tdata  = score_ff;

   for (genvar gi = 0; gi < TSIZE; gi++) begin : g_tab
      assign log_tab[gi] = log_entry(gi, TB);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oml_ff   <= ONE_MINUS_LAMBDA_RST;
         ilp_ff   <= INV_LAMBDA_PROB_RST;
         qb_ff    <= QUERY_BOOST_RST;
         merge_ff <= MERGE_WRITE;
         ufb_ff   <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_ONE_MINUS_LAMBDA: oml_ff   <= csr_data[15:0];
            REG_INV_LAMBDA_PROB:  ilp_ff   <= csr_data;
            REG_QUERY_BOOST:      qb_ff    <= csr_data[31:0];
            REG_MERGE_MODE:       merge_ff <= csr_data[1:0];
            REG_USE_FILTER_BOOST: ufb_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Input stage: scaled numerator into the top of the divider shift word.
   always_ff @(posedge clock) begin
      if (reset) begin
         div_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         div_vld_ff[0] <= req_tvalid;
      end
      if (adv) begin
         div_rem_ff[0]  <= '0;
         div_nq_ff[0]   <= {48'(oml_ff * req_tdata[31:0]), 16'd0};
         div_dl_ff[0]   <= req_tdata[63:32];
         div_side_ff[0] <= '{doc_boost: req_tdata[95:64], prior_score: req_tdata[127:96],
                             last: req_tlast, zero_len: (req_tdata[63:32] == 32'd0)};
      end
   end

   for (genvar gd = 0; gd < NDIV; gd++) begin : g_div
      logic [32:0] trial;
      logic        ge;
      assign trial = {div_rem_ff[gd], div_nq_ff[gd][63]};
      assign ge    = trial >= {1'b0, div_dl_ff[gd]};
      always_ff @(posedge clock) begin
         if (reset) begin
            div_vld_ff[gd+1] <= 1'b0;
         end else if (adv) begin
            div_vld_ff[gd+1] <= div_vld_ff[gd];
         end
         if (adv) begin
            div_rem_ff[gd+1]  <= ge ? 32'(trial - {1'b0, div_dl_ff[gd]}) : trial[31:0];
            div_nq_ff[gd+1]   <= {div_nq_ff[gd][62:0], ge};
            div_dl_ff[gd+1]   <= div_dl_ff[gd];
            div_side_ff[gd+1] <= div_side_ff[gd];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NPOST; i++) begin
            pv_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         pv_ff[0] <= div_vld_ff[NDIV];
         for (int i = 1; i < NPOST; i++) begin
            pv_ff[i] <= pv_ff[i-1];
         end
      end
      if (adv) begin
         ps_ff[0] <= div_side_ff[NDIV];
         for (int i = 1; i < NPOST; i++) begin
            ps_ff[i] <= ps_ff[i-1];
         end
      end
   end

   assign full_in = 112'(lo_ff) + (112'(mid_ff) << 32) + (112'(hi_ff) << 64);

   always_comb begin
      p_in = 6'd16;
      for (int i = 16; i < 49; i++) begin
         if (x_ff[i]) begin
            p_in = 6'(i);
         end
      end
   end

   assign xn_in      = x4_ff << (6'd48 - p_ff);
   assign round_in   = 55'(ll_ff) + 55'h0_8000_0000;
   assign partial_in = ps_ff[9].zero_len ? 22'd0 : round_in[53:32];
   assign sum_in     = 33'($signed(ps_ff[13].prior_score)) + 33'($signed(rf_ff));

   always_ff @(posedge clock) begin
      if (adv) begin
         m00_ff <= div_nq_ff[NDIV][31:0] * ilp_ff[31:0];
         m01_ff <= 64'(div_nq_ff[NDIV][31:0] * ilp_ff[47:32]);
         m10_ff <= div_nq_ff[NDIV][63:32] * ilp_ff[31:0];
         m11_ff <= 64'(div_nq_ff[NDIV][63:32] * ilp_ff[47:32]);
         mid_ff <= 65'(m01_ff) + 65'(m10_ff);
         lo_ff  <= m00_ff;
         hi_ff  <= m11_ff[47:0];
         ratio_ff <= (|full_in[111:64]) ? 48'hFFFF_FFFF_FFFF : full_in[63:16];
         x_ff   <= 49'(ratio_ff) + 49'd65536;
         x4_ff  <= x_ff;
         p_ff   <= p_in;
         f_ff   <= xn_in[47:16];
         e4_ff  <= p_ff - 6'd16;
         t0_ff  <= log_tab[f_ff[31:RW]];
         t1_ff  <= log_tab[(TB+1)'(f_ff[31:RW]) + (TB+1)'(1)];
         rem_ff <= f_ff[RW-1:0];
         e5_ff  <= e4_ff;
         dp_ff  <= (17'(t1_ff - t0_ff)) * rem_ff;
         t0b_ff <= t0_ff;
         e6_ff  <= e5_ff;
         l_ff   <= {e6_ff, 16'd0} + 22'(t0b_ff) + 22'(dp_ff >> RW);
         ll_ff  <= l_ff * LN2_Q32;
         pq_ff  <= $signed({1'b0, partial_in}) * $signed(qb_ff);
         r_ff   <= sat32(64'(pq_ff >>> 16));
         rfb_ff <= $signed(r_ff) * $signed(ps_ff[11].doc_boost);
         r11_ff <= r_ff;
         rf_ff  <= ufb_ff ? sat32(rfb_ff >>> 16) : r11_ff;
         case (merge_ff)
            MERGE_ADD: score_ff <= sat32(64'(sum_in));
            MERGE_MAX: score_ff <= ($signed(rf_ff) > $signed(ps_ff[13].prior_score)) ?
                                   rf_ff : ps_ff[13].prior_score;
            default:   score_ff <= rf_ff;
         endcase
      end
   end

endmodule

`default_nettype wire

[rtl/core/lmjm_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module lmjm_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [31:0]  rsp_tdata,
   input wire logic         rsp_tlast,
   input wire logic         csr_ready
);

   // The input side only stalls while a result waits to be taken.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled without a waiting result");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid straight after reset");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("configuration port not ready");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled result word changed");

endmodule

bind lm_jelinek_mercer_doc_scorer_core lmjm_checker u_lmjm_checker (.*);

`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import lmjm_pkg::*;

   localparam int          LATENCY_WAIT = 120;
   localparam int          CYCLE_LIMIT  = 600000;
   localparam logic [2:0]  REG_SPARE_5  = 3'd5;
   localparam logic [2:0]  REG_SPARE_7  = 3'd7;
   localparam logic [47:0] RATIO_TOP    = 48'hFFFF_FFFF_FFFF;

   typedef struct {
      logic [31:0] score;
      logic        block_end;
   } score_word_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [31:0]  rsp_tdata;
   logic         rsp_tlast;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_index = '0;
   logic [47:0]  csr_data = '0;

   logic [15:0]        jm_one_minus_lambda = ONE_MINUS_LAMBDA_RST;
   logic [47:0]        jm_inv_lambda_prob  = INV_LAMBDA_PROB_RST;
   logic signed [31:0] jm_query_boost      = QUERY_BOOST_RST;
   merge_type          jm_merge            = MERGE_WRITE;
   logic               jm_use_filter       = 1'b0;

   score_word_type pending_scores[$];
   int          mismatches = 0;
   int          cycles = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          hold_left = 0;

   lm_jelinek_mercer_doc_scorer_core u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic logic [16:0] log2_frac_q16(input int unsigned i);
      logic [63:0] acc;
      logic [16:0] bits;
      bits = '0;
      if (i >= 64) begin
         bits = 17'd65536;
      end else begin
         acc = 64'(64 + i) << 24;
         for (int k = 1; k <= 16; k++) begin
            acc = (acc * acc) >> 30;
            if (acc >= (64'd2 << 30)) begin
               acc = acc >> 1;
               bits[16 - k] = 1'b1;
            end
         end
      end
      return bits;
   endfunction

   function automatic logic signed [31:0] clip32(input longint v);
      logic signed [31:0] res;
      if (v > 64'sd2147483647) begin
         res = 32'sh7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         res = 32'sh8000_0000;
      end else begin
         res = v[31:0];
      end
      return res;
   endfunction

   function automatic logic [63:0] ln_one_plus(input logic [47:0] ratio);
      logic [63:0]  x;
      logic [63:0]  tmp;
      logic [31:0]  f;
      logic [63:0]  t0;
      logic [63:0]  t1;
      logic [63:0]  lg;
      int           p;
      x = 64'(ratio) + 64'd65536;
      p = 0;
      for (int s = 63; s >= 0; s--) begin
         if (x[s] && p == 0) begin
            p = s;
         end
      end
      if (p >= 32) begin
         tmp = x >> (p - 32);
      end else begin
         tmp = x << (32 - p);
      end
      f = tmp[31:0];
      t0 = 64'(log2_frac_q16(f[31:26]));
      t1 = 64'(log2_frac_q16(f[31:26] + 1));
      lg = (64'(p - 16) << 16) + t0 + (((t1 - t0) * 64'(f[25:0])) >> 26);
      return (lg * 64'(LN2_Q32) + 64'h8000_0000) >> 32;
   endfunction

   function automatic score_word_type predict_score(input logic [31:0] tf,
                                                    input logic [31:0] dl,
                                                    input logic signed [31:0] fb,
                                                    input logic signed [31:0] prior,
                                                    input logic last);
      score_word_type     res;
      logic [63:0]        num;
      logic [63:0]        q;
      logic [127:0]       wide;
      logic [47:0]        ratio;
      longint             partial;
      logic signed [31:0] r;
      longint             prod;
      partial = 0;
      if (dl != 0) begin
         num = (64'(jm_one_minus_lambda) * 64'(tf)) << 16;
         q = num / 64'(dl);
         wide = 128'(q) * 128'(jm_inv_lambda_prob);
         ratio = ((wide >> 16) > 128'(RATIO_TOP)) ? RATIO_TOP : wide[63:16];
         partial = longint'(ln_one_plus(ratio));
      end
      prod = partial * longint'(jm_query_boost);
      r = clip32(prod >>> 16);
      if (jm_use_filter) begin
         prod = longint'(r) * longint'(fb);
         r = clip32(prod >>> 16);
      end
      case (jm_merge)
         MERGE_ADD: begin
            res.score = clip32(longint'(prior) + longint'(r));
         end
         MERGE_MAX: begin
            res.score = (r > prior) ? r : prior;
         end
         default: begin
            res.score = r;
         end
      endcase
      res.block_end = last;
      return res;
   endfunction

   always @(posedge clock) begin
      score_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_scores.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result word score=%h last=%b", $time, rsp_tdata,
                     rsp_tlast);
         end else begin
            want = pending_scores.pop_front();
            if (rsp_tdata !== want.score) begin
               mismatches++;
               $display("%0t: score expected %h actual %h", $time, want.score, rsp_tdata);
            end
            if (rsp_tlast !== want.block_end) begin
               mismatches++;
               $display("%0t: block end expected %b actual %b", $time, want.block_end,
                        rsp_tlast);
            end
         end
      end
   end

   task automatic send_word(input logic [31:0] tf, input logic [31:0] dl,
                            input logic [31:0] fb, input logic [31:0] prior, input logic last);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do begin
            @(posedge clock);
         end while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {prior, fb, dl, tf};
      req_tlast <= last;
      do begin
         @(posedge clock);
      end while (!req_tready);
      pending_scores.push_back(predict_score(tf, dl, fb, prior, last));
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_scores.size() != 0) begin
         @(posedge clock);
      end
      repeat (LATENCY_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [47:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_ONE_MINUS_LAMBDA: jm_one_minus_lambda = value[15:0];
         REG_INV_LAMBDA_PROB:  jm_inv_lambda_prob = value;
         REG_QUERY_BOOST:      jm_query_boost = value[31:0];
         REG_MERGE_MODE:       jm_merge = merge_type'(value[1:0]);
         REG_USE_FILTER_BOOST: jm_use_filter = value[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_all(input logic [15:0] oml, input logic [47:0] ilp, input logic [31:0] qb,
                          input merge_type mm, input logic use_fb);
      drain_results();
      write_reg(REG_ONE_MINUS_LAMBDA, 48'(oml));
      write_reg(REG_INV_LAMBDA_PROB, ilp);
      write_reg(REG_QUERY_BOOST, 48'(qb));
      write_reg(REG_MERGE_MODE, 48'(mm));
      write_reg(REG_USE_FILTER_BOOST, 48'(use_fb));
   endtask

   task automatic send_random_word();
      logic [31:0] tf;
      logic [31:0] dl;
      logic [31:0] fb;
      logic [31:0] prior;
      case ($urandom_range(3))
         0: tf = $urandom;
         1: tf = $urandom_range(15);
         default: tf = $urandom_range(5000);
      endcase
      case ($urandom_range(5))
         0: dl = 32'd0;
         1: dl = $urandom;
         default: dl = $urandom_range(1, 3000);
      endcase
      fb = $urandom_range(1) ? $urandom : $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      prior = $urandom_range(1) ? $urandom : $urandom_range(0, 32'h0010_0000);
      send_word(tf, dl, fb, prior, 1'($urandom_range(1)));
   endtask

   task automatic test_directed();
      send_word(32'd0, 32'd10, 32'd0, 32'd0, 1'b0);
      send_word(32'd3, 32'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1);
      send_word(32'hFFFF_FFFF, 32'd1, 32'h8000_0000, 32'h8000_0000, 1'b0);
      send_word(32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd0, 1'b1);
      send_word(32'd5, 32'd100, 32'h0001_0000, 32'h1234_5678, 1'b0);
      set_all(16'hFFFF, RATIO_TOP, 32'h7FFF_FFFF, MERGE_ADD, 1'b0);
      send_word(32'hFFFF_FFFF, 32'd1, 32'd0, 32'h7FFF_FFFF, 1'b1);
      send_word(32'd1000, 32'd1, 32'd0, 32'h8000_0000, 1'b0);
      send_word(32'd7, 32'd0, 32'd0, 32'h7FFF_FFFF, 1'b1);
      set_all(16'd0, 48'd0, 32'h8000_0000, MERGE_MAX, 1'b1);
      send_word(32'd9, 32'd3, 32'h8000_0000, 32'h8000_0000, 1'b0);
      send_word(32'd9, 32'd0, 32'h7FFF_FFFF, 32'hFFFF_0000, 1'b1);
      set_all(16'd40000, 48'h0000_0100_0000, 32'h8000_0000, MERGE_SPARE, 1'b1);
      send_word(32'd50, 32'd3, 32'h8000_0000, 32'd0, 1'b0);
      send_word(32'd50, 32'd3, 32'h7FFF_FFFF, 32'd0, 1'b1);
      send_word(32'hFFFF_FFFF, 32'd2, 32'hFFFF_FFFF, 32'd0, 1'b0);
      drain_results();
      write_reg(REG_SPARE_5, RATIO_TOP);
      write_reg(REG_SPARE_7, 48'd0);
      send_word(32'd50, 32'd3, 32'h0002_0000, 32'd0, 1'b1);
   endtask

   task automatic test_random_settings(input int settings, input int words);
      logic [47:0] ilp;
      logic [15:0] oml;
      for (int s = 0; s < settings; s++) begin
         case ($urandom_range(3))
            0: ilp = 48'({$urandom, $urandom});
            1: ilp = RATIO_TOP;
            default: ilp = 48'($urandom_range(32'h0100_0000));
         endcase
         oml = ($urandom_range(4) == 0) ? 16'hFFFF : 16'($urandom);
         set_all(oml, ilp, ($urandom_range(1) ? $urandom : $urandom_range(32'h0004_0000)),
                 merge_type'($urandom_range(3)), 1'($urandom_range(1)));
         for (int n = 0; n < words; n++) begin
            send_random_word();
         end
      end
   endtask

   task automatic test_backpressure();
      set_all(ONE_MINUS_LAMBDA_RST, INV_LAMBDA_PROB_RST, QUERY_BOOST_RST, MERGE_ADD, 1'b1);
      hold_left = 400;
      for (int n = 0; n < 150; n++) begin
         send_random_word();
      end
   endtask

   task automatic test_pause();
      for (int n = 0; n < 30; n++) begin
         send_random_word();
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_scores.size() != 0) begin
         @(posedge clock);
      end
      for (int n = 0; n < 30; n++) begin
         send_random_word();
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      send_idle_pct = 33;
      recv_idle_pct = 60;
      test_random_settings(6, 90);
      send_idle_pct = 60;
      recv_idle_pct = 33;
      test_random_settings(6, 90);
      test_pause();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_settings(6, 90);
      test_backpressure();
      drain_results();
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
